@@ rtl/alm_pkg.sv @@
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants of the audio loopback latency meter.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int TEST_COUNT_DEF = 8;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 15;
  localparam int PHASE_W   = 3;
  localparam int TESTS_W   = 7;
  localparam int SUM_W     = 24;
  localparam int AVG_W     = 18;
  localparam int FRAME_W   = 32;
  localparam int NOISE_W   = 20;
  localparam int PINGLEN_W = 11;
  localparam int TIMEOUT_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  // reciprocal for the average: exact for sum < 2^SUM_W and divisor <= 64
  localparam int RCP_SHIFT = SUM_W + 6;
  localparam int RCP_W     = RCP_SHIFT + 1;

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FRAMES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PING_FRAMES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PING_AMPLITUDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_FRAMES = 3'd4;

  // register reset values
  localparam logic [NOISE_W-1:0]        NOISE_FRAMES_RST   = 20'd4096;
  localparam logic [LEVEL_W-1:0]        ECHO_THRESHOLD_RST = 15'd16384;
  localparam logic [PINGLEN_W-1:0]      PING_FRAMES_RST    = 11'd16;
  localparam logic signed [SAMPLE_W-1:0] PING_AMPLITUDE_RST = 16'sd29491;
  localparam logic [TIMEOUT_W-1:0]      TIMEOUT_FRAMES_RST = 18'd44100;

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // phase codes as reported on the output
  localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_NOISE   = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_WAIT    = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_DONE    = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_TIMEOUT = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_NOISE   = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_TIMEOUT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [NOISE_W-1:0]         noise_frames;
    logic [LEVEL_W-1:0]         echo_threshold;
    logic [PINGLEN_W-1:0]       ping_frames;
    logic signed [SAMPLE_W-1:0] ping_amplitude;
    logic [TIMEOUT_W-1:0]       timeout_frames;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [PHASE_W-1:0]         phase;
    logic [LEVEL_W-1:0]         noise_floor;
    logic                       echo_found;
    logic [TESTS_W-1:0]         tests;
    logic [SUM_W-1:0]           sum;
  } result_t;

endpackage

@@ rtl/alm_core.sv @@
// ----------------------------------------------------------------------------
// alm_core
// Calibration state and per-frame update: noise floor, ping, echo detection.
// ----------------------------------------------------------------------------
module alm_core #(
  parameter int TEST_COUNT = alm_pkg::TEST_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  alm_pkg::cfg_t                       cfg,
  input  logic                                opcode,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample_left,
  output alm_pkg::result_t                    res
);

  logic [alm_pkg::FRAME_W-1:0] frame_count, frame_count_next;
  logic [alm_pkg::FRAME_W-1:0] ping_start, ping_start_next;
  alm_pkg::phase_t             cal_phase, cal_phase_next;
  logic [alm_pkg::LEVEL_W-1:0] noise_peak, noise_peak_next;
  logic [alm_pkg::TESTS_W-1:0] tests_done, tests_done_next;
  logic [alm_pkg::SUM_W-1:0]   latency_sum, latency_sum_next;
  logic                        ping_pending, ping_pending_next;

  logic [alm_pkg::LEVEL_W-1:0] level;
  logic [alm_pkg::FRAME_W-1:0] delta;
  logic [alm_pkg::SUM_W:0]     sum_wide;
  logic [alm_pkg::SUM_W-1:0]   sum_sat;
  logic                        echo_hit;
  logic                        found;
  logic signed [alm_pkg::SAMPLE_W-1:0] sample_out;
  logic [alm_pkg::PHASE_W-1:0] phase_code;

  // absolute level, negative full scale saturates
  always_comb begin
    if (!sample_left[alm_pkg::SAMPLE_W-1]) begin
      level = sample_left[alm_pkg::LEVEL_W-1:0];
    end else if (sample_left[alm_pkg::LEVEL_W-1:0] == '0) begin
      level = {alm_pkg::LEVEL_W{1'b1}};
    end else begin
      level = alm_pkg::LEVEL_W'(-sample_left);
    end
  end

  assign delta    = frame_count - ping_start;
  assign echo_hit = level > cfg.echo_threshold;
  assign sum_wide = {1'b0, latency_sum} + {1'b0, delta[alm_pkg::SUM_W-1:0]};
  assign sum_sat  = ((delta[alm_pkg::FRAME_W-1:alm_pkg::SUM_W] != '0) ||
                     sum_wide[alm_pkg::SUM_W]) ? alm_pkg::SUM_MAX
                                               : sum_wide[alm_pkg::SUM_W-1:0];

  always_comb begin
    frame_count_next  = frame_count;
    ping_start_next   = ping_start;
    cal_phase_next    = cal_phase;
    noise_peak_next   = noise_peak;
    tests_done_next   = tests_done;
    latency_sum_next  = latency_sum;
    ping_pending_next = ping_pending;
    found             = 1'b0;
    sample_out        = '0;
    if (opcode == alm_pkg::OP_START) begin
      frame_count_next  = '0;
      ping_start_next   = '0;
      ping_pending_next = 1'b0;
      noise_peak_next   = '0;
      tests_done_next   = '0;
      latency_sum_next  = '0;
      cal_phase_next    = alm_pkg::PH_NOISE;
    end else if (cal_phase == alm_pkg::PH_NOISE || cal_phase == alm_pkg::PH_WAIT) begin
      frame_count_next = frame_count + 1'b1;
      if (frame_count < alm_pkg::FRAME_W'(cfg.noise_frames)) begin
        if (level > noise_peak) begin
          noise_peak_next = level;
        end
      end else begin
        if (ping_pending) begin
          if (echo_hit) begin
            latency_sum_next  = sum_sat;
            tests_done_next   = tests_done + 1'b1;
            found             = 1'b1;
            ping_pending_next = 1'b0;
            if (tests_done_next >= alm_pkg::TESTS_W'(TEST_COUNT)) begin
              cal_phase_next = alm_pkg::PH_DONE;
            end
          end else if (delta >= alm_pkg::FRAME_W'(cfg.timeout_frames)) begin
            cal_phase_next = alm_pkg::PH_TIMEOUT;
          end
        end
        // restart the ping while still measuring
        if ((cal_phase_next == alm_pkg::PH_NOISE || cal_phase_next == alm_pkg::PH_WAIT) &&
            !ping_pending_next) begin
          ping_start_next   = frame_count;
          ping_pending_next = 1'b1;
          cal_phase_next    = alm_pkg::PH_WAIT;
          if (cfg.ping_frames != '0) begin
            sample_out = cfg.ping_amplitude;
          end
        end else if (ping_pending_next && delta < alm_pkg::FRAME_W'(cfg.ping_frames)) begin
          sample_out = cfg.ping_amplitude;
        end
      end
    end
  end

  always_comb begin
    case (cal_phase_next)
      alm_pkg::PH_IDLE:    phase_code = alm_pkg::PHASE_IDLE;
      alm_pkg::PH_NOISE:   phase_code = alm_pkg::PHASE_NOISE;
      alm_pkg::PH_WAIT:    phase_code = alm_pkg::PHASE_WAIT;
      alm_pkg::PH_DONE:    phase_code = alm_pkg::PHASE_DONE;
      alm_pkg::PH_TIMEOUT: phase_code = alm_pkg::PHASE_TIMEOUT;
      default:             phase_code = alm_pkg::PHASE_IDLE;
    endcase
  end

  always_comb begin
    res.out_sample  = sample_out;
    res.phase       = phase_code;
    res.noise_floor = noise_peak_next;
    res.echo_found  = found;
    res.tests       = tests_done_next;
    res.sum         = latency_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      ping_start   <= '0;
      cal_phase    <= alm_pkg::PH_IDLE;
      noise_peak   <= '0;
      tests_done   <= '0;
      latency_sum  <= '0;
      ping_pending <= 1'b0;
    end else if (en) begin
      frame_count  <= frame_count_next;
      ping_start   <= ping_start_next;
      cal_phase    <= cal_phase_next;
      noise_peak   <= noise_peak_next;
      tests_done   <= tests_done_next;
      latency_sum  <= latency_sum_next;
      ping_pending <= ping_pending_next;
    end
  end

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    cal_phase == alm_pkg::PH_DONE |-> tests_done == alm_pkg::TESTS_W'(TEST_COUNT))
    else $error("done phase without the full test count");

  a_pending_phase: assert property (@(posedge clk) disable iff (rst)
    ping_pending |-> (cal_phase == alm_pkg::PH_WAIT || cal_phase == alm_pkg::PH_TIMEOUT))
    else $error("ping pending outside the waiting phases");

  a_sum_empty: assert property (@(posedge clk) disable iff (rst)
    tests_done == '0 |-> latency_sum == '0)
    else $error("latency sum without any test");

  a_found_count: assert property (@(posedge clk) disable iff (rst)
    en && found |=> tests_done == $past(tests_done) + 1'b1)
    else $error("echo did not count a test");

endmodule

@@ rtl/alm_avg.sv @@
// ----------------------------------------------------------------------------
// alm_avg
// Mean latency: latency sum times a reciprocal of the test count, registered.
// ----------------------------------------------------------------------------
module alm_avg #(
  parameter int TEST_COUNT = alm_pkg::TEST_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [alm_pkg::SUM_W-1:0]   sum,
  input  logic [alm_pkg::TESTS_W-1:0] tests,
  output logic [alm_pkg::AVG_W-1:0]   avg
);

  localparam int IDX_W  = $clog2(TEST_COUNT + 1);
  localparam int TAB_N  = 1 << IDX_W;
  localparam int PROD_W = alm_pkg::SUM_W + alm_pkg::RCP_W;
  localparam int QUO_W  = PROD_W - alm_pkg::RCP_SHIFT;

  logic [alm_pkg::RCP_W-1:0] rcp_tab [TAB_N];
  logic [PROD_W-1:0]         prod;
  logic [QUO_W-1:0]          quo;

  // ceil(2^shift / n); zero count gives a zero mean
  for (genvar g = 0; g < TAB_N; g++) begin : g_rcp
    localparam longint DIV = (g == 0) ? 1 : g;
    localparam logic [alm_pkg::RCP_W-1:0] RCP = (g == 0 || g > TEST_COUNT) ? '0 :
      alm_pkg::RCP_W'(((64'd1 << alm_pkg::RCP_SHIFT) + DIV - 1) / DIV);
    assign rcp_tab[g] = RCP;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(sum) * PROD_W'(rcp_tab[tests[IDX_W-1:0]]);
    end
  end

  assign quo = prod[PROD_W-1:alm_pkg::RCP_SHIFT];
  assign avg = (quo > QUO_W'(alm_pkg::AVG_MAX)) ? alm_pkg::AVG_MAX : quo[alm_pkg::AVG_W-1:0];

endmodule

@@ rtl/audio_loopback_latency_meter.sv @@
// ----------------------------------------------------------------------------
// audio_loopback_latency_meter
// Round-trip audio latency meter: noise floor, pings, echo timing, average.
// ----------------------------------------------------------------------------
// One item (a start command or one audio frame) is accepted every clock cycle
// while in_ready is high; the calibration state is updated in the accept cycle,
// and the mean latency is then formed by one multiplication of the latency sum
// with a tabulated reciprocal of the test count, which sits in its own register
// stage. A waiting result does not stop the next item from entering while the
// second stage is free. Registers may be written only while no item is in
// flight; the register port is always ready.
module audio_loopback_latency_meter #(
  parameter int TEST_COUNT = alm_pkg::TEST_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [alm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  opcode,
  input  logic signed [alm_pkg::SAMPLE_W-1:0]   sample_left,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [alm_pkg::SAMPLE_W-1:0]   out_sample,
  output logic [alm_pkg::PHASE_W-1:0]           phase,
  output logic [alm_pkg::LEVEL_W-1:0]           noise_floor,
  output logic                                  echo_found,
  output logic [alm_pkg::TESTS_W-1:0]           tests_completed,
  output logic [alm_pkg::AVG_W-1:0]             latency_average
);

  alm_pkg::cfg_t    cfg;
  alm_pkg::result_t core_res;
  alm_pkg::result_t s1_res;
  alm_pkg::result_t s2_res;
  logic             s1_valid;
  logic             s2_valid;
  logic             in_accept;
  logic             s2_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_frames   <= alm_pkg::NOISE_FRAMES_RST;
      cfg.echo_threshold <= alm_pkg::ECHO_THRESHOLD_RST;
      cfg.ping_frames    <= alm_pkg::PING_FRAMES_RST;
      cfg.ping_amplitude <= alm_pkg::PING_AMPLITUDE_RST;
      cfg.timeout_frames <= alm_pkg::TIMEOUT_FRAMES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        alm_pkg::REG_NOISE_FRAMES:   cfg.noise_frames   <= cfg_data;
        alm_pkg::REG_ECHO_THRESHOLD: cfg.echo_threshold <= cfg_data[alm_pkg::LEVEL_W-1:0];
        alm_pkg::REG_PING_FRAMES:    cfg.ping_frames    <= cfg_data[alm_pkg::PINGLEN_W-1:0];
        alm_pkg::REG_PING_AMPLITUDE: cfg.ping_amplitude <= cfg_data[alm_pkg::SAMPLE_W-1:0];
        alm_pkg::REG_TIMEOUT_FRAMES: cfg.timeout_frames <= cfg_data[alm_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // two-stage result pipeline
  assign s2_load   = s1_valid && (!s2_valid || out_ready);
  assign in_ready  = !s1_valid || !s2_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  alm_core #(
    .TEST_COUNT(TEST_COUNT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (in_accept),
    .cfg        (cfg),
    .opcode     (opcode),
    .sample_left(sample_left),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res <= core_res;
    end
    if (s2_load) begin
      s2_res <= s1_res;
    end
  end

  alm_avg #(
    .TEST_COUNT(TEST_COUNT)
  ) u_avg (
    .clk  (clk),
    .en   (s2_load),
    .sum  (s1_res.sum),
    .tests(s1_res.tests),
    .avg  (latency_average)
  );

  assign out_valid       = s2_valid;
  assign out_sample      = s2_res.out_sample;
  assign phase           = s2_res.phase;
  assign noise_floor     = s2_res.noise_floor;
  assign echo_found      = s2_res.echo_found;
  assign tests_completed = s2_res.tests;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |-> !in_accept)
    else $error("first stage overwritten while held");

  a_s2_fill: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> s2_valid)
    else $error("second stage load lost");

  a_s1_drain: assert property (@(posedge clk) disable iff (rst)
    s2_load && !in_accept |=> !s1_valid)
    else $error("first stage not emptied after transfer");

endmodule

@@ test/audio_loopback_latency_meter_test.sv @@
// ----------------------------------------------------------------------------
// audio_loopback_latency_meter_test
// Self-checking bench for the latency meter. A directed table runs first, then
// random calibration runs under several register settings. Every result is
// compared field by field with a behavioral copy of the meter (typed table rows
// with their listed values), while both handshake sides idle at varying rates.
// ----------------------------------------------------------------------------
module audio_loopback_latency_meter_test;
  import alm_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int RANDOM_ITEMS = 400;
  localparam int RANDOM_RUNS  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [PHASE_W-1:0]         phase;
    logic [LEVEL_W-1:0]         noise_floor;
    logic                       echo_found;
    logic [TESTS_W-1:0]         tests;
    logic [AVG_W-1:0]           average;
  } meter_result_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CFG_IDX_W-1:0]       index;
    logic [CFG_DATA_W-1:0]      data;
    bit                         typed;
    meter_result_t              want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        opcode = OP_FRAME;
  logic signed [SAMPLE_W-1:0]  sample_left = '0;
  logic                        out_ready = 1'b0;
  logic                        cfg_ready;
  logic                        in_ready;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  out_sample;
  logic [PHASE_W-1:0]          phase;
  logic [LEVEL_W-1:0]          noise_floor;
  logic                        echo_found;
  logic [TESTS_W-1:0]          tests_completed;
  logic [AVG_W-1:0]            latency_average;

  audio_loopback_latency_meter i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .sample_left     (sample_left),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .phase           (phase),
    .noise_floor     (noise_floor),
    .echo_found      (echo_found),
    .tests_completed (tests_completed),
    .latency_average (latency_average)
  );

  always #6 clk = ~clk;

  // meter registers and calibration state as the bench sees them
  logic [NOISE_W-1:0]         m_noise_frames;
  logic [LEVEL_W-1:0]         m_threshold;
  logic [PINGLEN_W-1:0]       m_ping_frames;
  logic signed [SAMPLE_W-1:0] m_ping_amp;
  logic [TIMEOUT_W-1:0]       m_timeout;
  logic [FRAME_W-1:0]         m_frame;
  logic [FRAME_W-1:0]         m_ping_start;
  logic [PHASE_W-1:0]         m_phase;
  logic [LEVEL_W-1:0]         m_peak;
  logic [TESTS_W-1:0]         m_tests;
  logic [SUM_W-1:0]           m_sum;
  bit                         m_pending;

  meter_result_t expected_results[$];
  stim_row_t     stim_table[$];

  int sender_idle   = 26;
  int receiver_idle = 61;
  int errors        = 0;
  int item_count    = 0;
  int result_count  = 0;
  int echo_count    = 0;
  int finished_runs = 0;
  int cycle_count   = 0;

  function automatic void meter_reset();
    m_noise_frames = NOISE_FRAMES_RST;
    m_threshold    = ECHO_THRESHOLD_RST;
    m_ping_frames  = PING_FRAMES_RST;
    m_ping_amp     = PING_AMPLITUDE_RST;
    m_timeout      = TIMEOUT_FRAMES_RST;
    m_frame        = '0;
    m_ping_start   = '0;
    m_phase        = PHASE_IDLE;
    m_peak         = '0;
    m_tests        = '0;
    m_sum          = '0;
    m_pending      = 1'b0;
  endfunction

  function automatic void meter_write(input logic [CFG_IDX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] data);
    case (index)
      REG_NOISE_FRAMES:   m_noise_frames = data[NOISE_W-1:0];
      REG_ECHO_THRESHOLD: m_threshold    = data[LEVEL_W-1:0];
      REG_PING_FRAMES:    m_ping_frames  = data[PINGLEN_W-1:0];
      REG_PING_AMPLITUDE: m_ping_amp     = data[SAMPLE_W-1:0];
      REG_TIMEOUT_FRAMES: m_timeout      = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic meter_result_t meter_step(input logic op,
                                               input logic signed [SAMPLE_W-1:0] s);
    meter_result_t              r;
    logic [LEVEL_W-1:0]         level;
    logic signed [SAMPLE_W-1:0] neg;
    logic [FRAME_W-1:0]         d;
    logic [FRAME_W:0]           total;
    logic [SUM_W-1:0]           q;
    neg = -s;
    // negative full scale saturates
    if (s == {1'b1, {(SAMPLE_W-1){1'b0}}}) level = {LEVEL_W{1'b1}};
    else if (s < 0) level = neg[LEVEL_W-1:0];
    else level = s[LEVEL_W-1:0];
    r.out_sample = '0;
    r.echo_found = 1'b0;
    if (op == OP_START) begin
      m_frame      = '0;
      m_ping_start = '0;
      m_pending    = 1'b0;
      m_peak       = '0;
      m_tests      = '0;
      m_sum        = '0;
      m_phase      = PHASE_NOISE;
    end else if (m_phase == PHASE_NOISE || m_phase == PHASE_WAIT) begin
      if (m_frame < m_noise_frames) begin
        if (level > m_peak) m_peak = level;
      end else begin
        if (m_pending) begin
          d = m_frame - m_ping_start;
          if (level > m_threshold) begin
            total = m_sum + d;
            if (total > SUM_MAX) m_sum = SUM_MAX;
            else m_sum = total[SUM_W-1:0];
            if (m_tests != {TESTS_W{1'b1}}) m_tests++;
            r.echo_found = 1'b1;
            m_pending = 1'b0;
            if (m_tests >= TEST_COUNT_DEF) m_phase = PHASE_DONE;
          end else if (d >= m_timeout) begin
            m_phase = PHASE_TIMEOUT;
          end
        end
        // re-ping on the same frame that closed a measurement
        if ((m_phase == PHASE_NOISE || m_phase == PHASE_WAIT) && !m_pending) begin
          m_ping_start = m_frame;
          m_pending    = 1'b1;
          m_phase      = PHASE_WAIT;
        end
        d = m_frame - m_ping_start;
        if (m_pending && d < m_ping_frames) r.out_sample = m_ping_amp;
      end
      m_frame++;
    end
    r.phase       = m_phase;
    r.noise_floor = m_peak;
    r.tests       = m_tests;
    if (m_tests == '0) begin
      r.average = '0;
    end else begin
      q = m_sum / m_tests;
      if (q > AVG_MAX) r.average = AVG_MAX;
      else r.average = q[AVG_W-1:0];
    end
    return r;
  endfunction

  task automatic add_item(input logic op, input logic signed [SAMPLE_W-1:0] s);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: op, sample: s, index: '0, data: '0, typed: 1'b0,
            want: '{default: '0}};
    stim_table.push_back(row);
  endtask

  task automatic add_typed(input logic op, input logic signed [SAMPLE_W-1:0] s,
                           input logic [PHASE_W-1:0] ph, input int nf,
                           input int tests, input int avg);
    stim_row_t row;
    row = '{kind: ROW_ITEM, op: op, sample: s, index: '0, data: '0, typed: 1'b1,
            want: '{default: '0}};
    row.want.phase       = ph;
    row.want.noise_floor = LEVEL_W'(nf);
    row.want.tests       = TESTS_W'(tests);
    row.want.average     = AVG_W'(avg);
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] index,
                         input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, op: OP_FRAME, sample: '0, index: index, data: data,
            typed: 1'b0, want: '{default: '0}};
    stim_table.push_back(row);
  endtask

  task automatic report(input string what, input longint got, input longint want_v);
    errors++;
    if (errors <= 40) $display("mismatch: %s got %0d expected %0d", what, got, want_v);
  endtask

  task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] s,
                           input bit typed, input meter_result_t want);
    meter_result_t      pred;
    logic [PHASE_W-1:0] old_phase;
    bit                 taken;
    if (cfg_valid) cfg_valid <= 1'b0;
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    sample_left <= s;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    old_phase = m_phase;
    pred = meter_step(op, s);
    expected_results.push_back(typed ? want : pred);
    item_count++;
    if (pred.echo_found) echo_count++;
    if (pred.phase != old_phase && (pred.phase == PHASE_DONE || pred.phase == PHASE_TIMEOUT))
      finished_runs++;
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    bit taken;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    meter_write(index, data);
  endtask

  task automatic random_settings(input int run);
    logic [NOISE_W-1:0]   nf;
    logic [LEVEL_W-1:0]   thr;
    logic [PINGLEN_W-1:0] pf;
    logic [SAMPLE_W-1:0]  amp;
    logic [TIMEOUT_W-1:0] tmo;
    logic [31:0]          junk;
    case (run)
      0: begin
        nf = '0; thr = '0; pf = 11'd1; amp = 16'h8000; tmo = 18'd1;
      end
      1: begin
        nf = '0; thr = 15'h7FFF; pf = 11'd1024; amp = 16'h7FFF; tmo = 18'h3FFFF;
      end
      default: begin
        nf  = NOISE_W'($urandom_range(6));
        thr = LEVEL_W'($urandom_range(32767));
        pf  = PINGLEN_W'($urandom_range(12, 1));
        amp = SAMPLE_W'($urandom);
        tmo = TIMEOUT_W'($urandom_range(24, 1));
        if (run == 2) nf = '1;
      end
    endcase
    // unused upper data bits carry noise
    junk = $urandom;
    write_reg(REG_NOISE_FRAMES, nf);
    write_reg(REG_ECHO_THRESHOLD, {junk[4:0], thr});
    write_reg(REG_PING_FRAMES, {junk[13:5], pf});
    write_reg(REG_PING_AMPLITUDE, {junk[17:14], amp});
    write_reg(REG_TIMEOUT_FRAMES, {junk[19:18], tmo});
    write_reg(REG_SPARE, junk[31:12]);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_idle);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("run stopped at cycle limit with %0d results outstanding",
               expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin : check_results
    meter_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("result with nothing expected, phase", phase, 0);
      end else begin
        want = expected_results.pop_front();
        result_count++;
        if (out_sample !== want.out_sample) report("out_sample", out_sample, want.out_sample);
        if (phase !== want.phase) report("phase", phase, want.phase);
        if (noise_floor !== want.noise_floor)
          report("noise_floor", noise_floor, want.noise_floor);
        if (echo_found !== want.echo_found) report("echo_found", echo_found, want.echo_found);
        if (tests_completed !== want.tests)
          report("tests_completed", tests_completed, want.tests);
        if (latency_average !== want.average)
          report("latency_average", latency_average, want.average);
      end
    end
  end

  initial begin
    meter_result_t              blank;
    logic                       op;
    logic signed [SAMPLE_W-1:0] s;
    logic [LEVEL_W-1:0]         mag;
    int                         r;
    int                         counted;
    int                         random_sent;
    bit                         ignored;

    blank = '{default: '0};
    meter_reset();

    // frames before any start are ignored
    add_typed(OP_FRAME, 16'sh8000, PHASE_IDLE, 0, 0, 0);
    add_typed(OP_FRAME, 16'sh7FFF, PHASE_IDLE, 0, 0, 0);
    add_typed(OP_START, 16'sh1234, PHASE_NOISE, 0, 0, 0);
    add_typed(OP_FRAME, 16'sh8000, PHASE_NOISE, 32767, 0, 0);
    add_item(OP_FRAME, 16'sd1);
    // short noise window, narrow ping, tight timeout
    add_cfg(REG_NOISE_FRAMES, 20'd2);
    add_cfg(REG_ECHO_THRESHOLD, 20'd1000);
    add_cfg(REG_PING_FRAMES, 20'd3);
    add_cfg(REG_PING_AMPLITUDE, 20'h08000);
    add_cfg(REG_TIMEOUT_FRAMES, 20'd4);
    add_typed(OP_START, 16'sd0, PHASE_NOISE, 0, 0, 0);
    add_item(OP_FRAME, 16'sd5);
    add_item(OP_FRAME, -16'sd7);
    add_item(OP_FRAME, 16'sd0);
    add_item(OP_FRAME, 16'sd0);
    add_item(OP_FRAME, 16'sd2000);
    add_item(OP_FRAME, 16'sd1000);
    add_item(OP_FRAME, -16'sd1001);
    add_item(OP_FRAME, 16'sd0);
    add_item(OP_FRAME, 16'sd0);
    add_item(OP_FRAME, 16'sd0);
    add_item(OP_FRAME, 16'sd0);
    add_typed(OP_FRAME, 16'sh7FFF, PHASE_TIMEOUT, 7, 2, 2);
    // zero noise window, threshold, ping length and timeout
    add_cfg(REG_NOISE_FRAMES, 20'd0);
    add_cfg(REG_ECHO_THRESHOLD, 20'd0);
    add_cfg(REG_PING_FRAMES, 20'd0);
    add_cfg(REG_TIMEOUT_FRAMES, 20'd0);
    add_typed(OP_START, 16'sh8000, PHASE_NOISE, 0, 0, 0);
    add_item(OP_FRAME, 16'sd0);
    add_item(OP_FRAME, 16'sd1);
    add_item(OP_FRAME, 16'sd0);
    add_typed(OP_FRAME, -16'sd1, PHASE_TIMEOUT, 0, 1, 1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG)
        write_reg(stim_table[i].index, stim_table[i].data);
      else
        send_item(stim_table[i].op, stim_table[i].sample, stim_table[i].typed,
                  stim_table[i].want);
    end

    random_sent = 0;
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      random_settings(run);
      send_item(OP_START, SAMPLE_W'($urandom), 1'b0, blank);
      counted = 1;
      while (counted < RANDOM_ITEMS / RANDOM_RUNS) begin
        r = $urandom_range(99);
        ignored = 1'b0;
        op = OP_FRAME;
        s = SAMPLE_W'($urandom);
        if (m_phase == PHASE_IDLE || m_phase == PHASE_DONE || m_phase == PHASE_TIMEOUT) begin
          if (r < 40) op = OP_START;
          else ignored = 1'b1;
        end else if (r < 3) begin
          op = OP_START;
        end else if (r < 10) begin
          op = 1'($urandom_range(1));
        end else if (m_frame >= m_noise_frames) begin
          // echo hunting: mostly quiet frames with the odd loud one
          if (r < 38 && m_threshold != {LEVEL_W{1'b1}}) begin
            mag = LEVEL_W'($urandom_range(32767, int'(m_threshold) + 1));
            s = {1'b0, mag};
            if ($urandom_range(1)) begin
              if (mag == {LEVEL_W{1'b1}} && $urandom_range(1)) s = 16'sh8000;
              else s = -s;
            end
          end else begin
            mag = LEVEL_W'($urandom_range(int'(m_threshold), 0));
            s = {1'b0, mag};
            if ($urandom_range(1)) s = -s;
          end
        end
        send_item(op, s, 1'b0, blank);
        if (!ignored) begin
          counted++;
          random_sent++;
          if (random_sent == RANDOM_ITEMS / 3) begin
            sender_idle   = 61;
            receiver_idle = 26;
          end else if (random_sent == 2 * RANDOM_ITEMS / 3) begin
            sender_idle   = 0;
            receiver_idle = 0;
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d items over %0d register settings, checked %0d results",
             item_count, RANDOM_RUNS + 3, result_count);
    $display("saw %0d echoes and %0d runs ending done or timed out, %0d mismatches",
             echo_count, finished_runs, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
